// ----- hw/rtl/mqpq_pkg.sv -----
`default_nettype none

package mqpq_pkg;

  // Bank geometry.
  localparam int NUM_QUEUES = 16;
  localparam int LEVELS     = 5;
  localparam int VALUE_BITS = 32;

  // Port field widths are fixed by the interface.
  localparam int QID_BITS  = 4;
  localparam int DATA_BITS = 32;
  localparam int IN_BITS   = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;

  localparam int NODES_PER_QUEUE = (1 << LEVELS) - 1;
  localparam int SLOTS_PER_QUEUE = 2 * NODES_PER_QUEUE;
  localparam int ROWS            = NUM_QUEUES * NODES_PER_QUEUE;
  localparam int ROW_AW          = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NODE_BITS       = LEVELS;
  localparam int COUNT_BITS      = LEVELS;
  localparam int TOTAL_BITS      = COUNT_BITS + 1;
  localparam int LEVEL_BITS      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int QPROD_BITS      = QID_BITS + NODE_BITS;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [NODE_BITS-1:0]  node_t;
  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [ROW_AW-1:0]     row_addr_t;

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_PUSHED = 2'd0,
    STAT_POPPED = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [QID_BITS-1:0] queue_id;
    logic [DATA_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [DATA_BITS-1:0] popped_value;
  } rsp_t;

  // One heap node: two slots, each with a valid bit, a subtree count and a value.
  typedef struct packed {
    logic [1:0]         valid;
    logic [1:0][COUNT_BITS-1:0] count;
    logic [1:0][VALUE_BITS-1:0] value;
  } row_t;

  // What the node unit does in the current cycle.
  typedef enum logic [1:0] {
    K_PUSH     = 2'd0,
    K_POP_ROOT = 2'd1,
    K_POP_PULL = 2'd2
  } kind_t;

  // Decision from the node unit back to the sequencer.
  typedef struct packed {
    logic    done;
    logic    write;
    logic    dir;
    status_t status;
  } step_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PUSH,
    S_POP_ROOT,
    S_POP_PULL,
    S_REPLY
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mqpq_node_mem.sv -----
`default_nettype none

module mqpq_node_mem (
  input  wire logic                clk,
  input  wire logic                rd_en,
  input  wire mqpq_pkg::row_addr_t rd_addr,
  output mqpq_pkg::row_t           rd_row,
  input  wire logic                wr_en,
  input  wire mqpq_pkg::row_addr_t wr_addr,
  input  wire mqpq_pkg::row_t      wr_row
);
  import mqpq_pkg::*;

  row_t mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mqpq_node_unit.sv -----
`default_nettype none

module mqpq_node_unit (
  input  wire mqpq_pkg::kind_t  kind,
  input  wire mqpq_pkg::row_t   row_a,
  input  wire mqpq_pkg::row_t   row_b,
  input  wire mqpq_pkg::value_t x,
  input  wire logic             dir_in,
  input  wire logic             is_root,
  input  wire logic             is_last,
  output mqpq_pkg::row_t        row_out,
  output mqpq_pkg::value_t      val_out,
  output mqpq_pkg::step_t       step
);
  import mqpq_pkg::*;

  logic      push_dir;
  logic      gt;
  value_t    cmp_a;
  value_t    cmp_b;
  logic [TOTAL_BITS-1:0] total;
  logic      a_sel;
  logic      a_none;
  logic      b_sel;
  logic      b_none;

  assign push_dir = row_a.count[0] > row_a.count[1];
  assign total    = TOTAL_BITS'(row_a.count[0]) + TOTAL_BITS'(row_a.count[1]) +
                    TOTAL_BITS'(row_a.valid[0]) + TOTAL_BITS'(row_a.valid[1]);

  // The one value comparator, shared by every kind of step.
  always_comb begin
    unique case (kind)
      K_PUSH: begin
        cmp_a = row_a.value[push_dir];
        cmp_b = x;
      end
      K_POP_ROOT: begin
        cmp_a = row_a.value[0];
        cmp_b = row_a.value[1];
      end
      K_POP_PULL: begin
        cmp_a = row_b.value[0];
        cmp_b = row_b.value[1];
      end
      default: begin
        cmp_a = row_a.value[0];
        cmp_b = row_a.value[1];
      end
    endcase
  end

  assign gt = cmp_a > cmp_b;

  // Minimum slot of a row; slot 0 wins a tie.
  assign a_none = ~row_a.valid[0] & ~row_a.valid[1];
  assign a_sel  = (row_a.valid[0] & row_a.valid[1]) ? gt : ~row_a.valid[0];
  assign b_none = ~row_b.valid[0] & ~row_b.valid[1];
  assign b_sel  = (row_b.valid[0] & row_b.valid[1]) ? gt : ~row_b.valid[0];

  always_comb begin
    row_out     = row_a;
    val_out     = x;
    step.done   = 1'b0;
    step.write  = 1'b0;
    step.dir    = 1'b0;
    step.status = STAT_PUSHED;
    unique case (kind)
      K_PUSH: begin
        priority if (is_root && (total >= TOTAL_BITS'(SLOTS_PER_QUEUE))) begin
          step.done   = 1'b1;
          step.status = STAT_FULL;
        end else if (!row_a.valid[0]) begin
          row_out.valid[0] = 1'b1;
          row_out.value[0] = x;
          step.write       = 1'b1;
          step.done        = 1'b1;
        end else if (!row_a.valid[1]) begin
          row_out.valid[1] = 1'b1;
          row_out.value[1] = x;
          step.write       = 1'b1;
          step.done        = 1'b1;
        end else if (is_last) begin
          step.done   = 1'b1;
          step.status = STAT_FULL;
        end else begin
          // The smaller value stays; the larger one (the new one on a tie) goes down.
          step.dir   = push_dir;
          step.write = 1'b1;
          if (gt) begin
            row_out.value[push_dir] = x;
            val_out                 = row_a.value[push_dir];
          end
          row_out.count[push_dir] = row_a.count[push_dir] + COUNT_BITS'(1);
        end
      end
      K_POP_ROOT: begin
        if (a_none) begin
          step.done   = 1'b1;
          step.status = STAT_EMPTY;
        end else begin
          step.dir = a_sel;
          val_out  = row_a.value[a_sel];
        end
      end
      K_POP_PULL: begin
        step.write  = 1'b1;
        step.status = STAT_POPPED;
        if ((row_a.count[dir_in] == '0) || is_last || b_none) begin
          row_out.valid[dir_in] = 1'b0;
          step.done             = 1'b1;
        end else begin
          row_out.value[dir_in] = row_b.value[b_sel];
          row_out.count[dir_in] = row_a.count[dir_in] - COUNT_BITS'(1);
          step.dir              = b_sel;
        end
      end
      default: begin
        step.done = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/multi_queue_balanced_heap_pq_core.sv -----
`default_nettype none

// Bank of NUM_QUEUES independent min-priority queues, selected per word by
// queue_id. Each queue is a balanced binary tree of LEVELS levels whose nodes
// hold two slots; a push fills the first free slot on its way down, otherwise
// it follows the slot whose subtree holds fewer items, keeping the smaller
// value and carrying the larger one down. A pop returns the smaller root slot
// (slot 0 on a tie) and refills slots level by level from below. All nodes of
// all queues live in one memory with one row per node, one read and one
// write port, and the row walk is what sets the timing: after acceptance a
// push visits one node per level on its way down, a pop reads the root and
// then refills one level at a time, and then the response register is
// loaded. The response register lets the next word be accepted while the
// previous response is still held; if that older response has still not been
// taken when the next one is ready, loading waits until it is. After reset
// the block sweeps the node memory once to empty every queue, one row per
// cycle across all NUM_QUEUES*(2^LEVELS-1) rows (496 at the default size);
// req_ready stays low during that sweep. A queue_id beyond the bank answers a
// push as full and a pop as empty without touching any queue.
module multi_queue_balanced_heap_pq_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire mqpq_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output mqpq_pkg::rsp_t       rsp
);
  import mqpq_pkg::*;

  state_t    state;
  state_t    state_next;
  row_addr_t clr_addr;

  // Per-word working registers.
  row_addr_t qbase;
  node_t     node;
  level_t    level;
  value_t    x;
  row_t      cur;
  logic      dir;
  status_t   res_status;
  value_t    res_value;

  // Memory ports.
  logic      rd_en;
  row_addr_t rd_addr;
  row_t      rd_row;
  logic      wr_en;
  row_addr_t wr_addr;
  row_t      wr_row;

  // Node unit.
  kind_t     kind;
  row_t      row_a;
  row_t      row_out;
  value_t    val_out;
  step_t     step;
  logic      is_root;
  logic      is_last;
  logic      next_last;

  logic                  q_ok;
  logic [QPROD_BITS-1:0] qprod;
  row_addr_t             req_qbase;
  logic                  rsp_free;
  node_t                 child;

  function automatic node_t child_of(node_t n, logic d);
    logic [NODE_BITS:0] t;
    t = {n, 1'b0} + {{NODE_BITS{1'b0}}, 1'b1} + {{NODE_BITS{1'b0}}, d};
    return t[NODE_BITS-1:0];
  endfunction

  assign q_ok      = int'(req.queue_id) < NUM_QUEUES;
  assign qprod     = QPROD_BITS'(req.queue_id) * QPROD_BITS'(NODES_PER_QUEUE);
  assign req_qbase = ROW_AW'(qprod);
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign is_root   = level == '0;
  assign is_last   = level == LEVEL_BITS'(LEVELS - 1);
  assign next_last = (level + LEVEL_BITS'(1)) == LEVEL_BITS'(LEVELS - 1);
  assign child     = child_of(node, (state == S_POP_PULL) ? dir : step.dir);

  assign row_a = (state == S_POP_PULL) ? cur : rd_row;

  always_comb begin
    unique case (state)
      S_PUSH:     kind = K_PUSH;
      S_POP_ROOT: kind = K_POP_ROOT;
      default:    kind = K_POP_PULL;
    endcase
  end

  mqpq_node_unit u_unit (
    .kind    (kind),
    .row_a   (row_a),
    .row_b   (rd_row),
    .x       (x),
    .dir_in  (dir),
    .is_root (is_root),
    .is_last (is_last),
    .row_out (row_out),
    .val_out (val_out),
    .step    (step)
  );

  mqpq_node_mem u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == ROW_AW'(ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          priority if (!q_ok) begin
            state_next = S_REPLY;
          end else if (req.cmd == CMD_PUSH) begin
            state_next = S_PUSH;
          end else begin
            state_next = S_POP_ROOT;
          end
        end
      end
      S_PUSH: begin
        if (step.done) begin
          state_next = S_REPLY;
        end
      end
      S_POP_ROOT: begin
        state_next = step.done ? S_REPLY : S_POP_PULL;
      end
      S_POP_PULL: begin
        if (step.done) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory control and handshake outputs.
  always_comb begin
    req_ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = qbase + ROW_AW'(child);
    wr_en     = 1'b0;
    wr_addr   = qbase + ROW_AW'(node);
    wr_row    = row_out;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_row  = '0;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        rd_en     = req_valid && q_ok;
        rd_addr   = req_qbase;
      end
      S_PUSH: begin
        wr_en = step.write;
        rd_en = !step.done;
      end
      S_POP_ROOT: begin
        rd_en = !step.done && !is_last;
      end
      S_POP_PULL: begin
        // Fetch the grandchild while the refilled parent is written back.
        wr_en   = step.write;
        rd_en   = !step.done && !next_last;
        rd_addr = qbase + ROW_AW'(child_of(child, step.dir));
      end
      S_REPLY: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ROW_AW'(1);
      end
      if ((state == S_REPLY) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers of the walk.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          qbase      <= req_qbase;
          x          <= value_t'(req.value[IN_BITS-1:0]);
          node       <= '0;
          level      <= '0;
          res_value  <= '0;
          res_status <= (req.cmd == CMD_POP) ? STAT_EMPTY : STAT_FULL;
        end
      end
      S_PUSH: begin
        if (step.done) begin
          res_status <= step.status;
        end else begin
          x     <= val_out;
          node  <= child;
          level <= level + LEVEL_BITS'(1);
        end
      end
      S_POP_ROOT: begin
        cur <= rd_row;
        dir <= step.dir;
        if (step.done) begin
          res_status <= step.status;
        end else begin
          res_value <= val_out;
        end
      end
      S_POP_PULL: begin
        if (step.done) begin
          res_status <= step.status;
        end else begin
          cur   <= rd_row;
          dir   <= step.dir;
          node  <= child;
          level <= level + LEVEL_BITS'(1);
        end
      end
      S_REPLY: begin
        if (rsp_free) begin
          rsp.status       <= res_status;
          rsp.popped_value <= DATA_BITS'(res_value[IN_BITS-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
